[hdl/spla_pkg.sv]
// Shared types, codes and defaults for the scan packet line assembler.
package spla_pkg;

  localparam int PACKET_BYTES_DEF      = 256;
  localparam int PIXEL_OFFSET_DEF      = 16;
  localparam int PIXELS_PER_PACKET_DEF = 216;
  localparam int BLOCKS_PER_LINE_DEF   = 8;
  localparam int MAX_SLOTS_DEF         = 4800;

  localparam logic [7:0]  HEADER_MARK = 8'h47;
  localparam logic [12:0] LIMIT_RESET = 13'd4800;

  // Header bytes inside a packet
  localparam int POS_HEADER = 4;
  localparam int POS_LINE_LO = 5;
  localparam int POS_LINE_MID = 6;
  localparam int POS_LINE_HI = 7;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_PACKET    = 2'd0,
    CMD_READ      = 2'd1,
    CMD_NEW_FRAME = 2'd2,
    CMD_NOP       = 2'd3
  } cmd_t;

  // Per-item info passed from the front to the back
  typedef struct packed {
    logic        is_read;
    logic        committed;
    logic [19:0] scan_line;
    logic [12:0] slot_index;
    logic        frame_full;
  } meta_t;

  // Result item, last listed field in the lowest bits
  typedef struct packed {
    logic [7:0]  read_data;
    logic        frame_full;
    logic [12:0] slot_index;
    logic [19:0] scan_line;
    logic        line_committed;
  } result_t;

endpackage

[hdl/scan_packet_line_assembler_core.sv]
// Scan packet line assembler top level.
//
// Input channel s_axis: one item per handshake. tuser carries the command
// (packet byte, read line store byte, start new frame, no-op); tdata carries
// the packet byte, the capture enable and the line store read address.
// Output channel m_axis: exactly one result item for every input item, in order:
// commit flag, line number, slot index, frame full flag and read data.
// Configuration: cfg_we writes cfg_wdata into the frame line limit (reset 4800).
//
// Throughput is one item per cycle while s_axis_tready is high. A result is
// offered on m_axis after its item has passed the read stage into the queue:
// the line store read is registered at the accepting edge and the result enters
// the queue at the next one. A four-entry result queue decouples the two sides;
// when the receiver stalls, s_axis_tready drops once the queue and the read
// stage hold four items, and no result is ever lost.
//
// After reset the line store is cleared one byte per cycle, all
// PIXELS_PER_PACKET * BLOCKS_PER_LINE bytes (1728 by default); s_axis_tready
// stays low for that time. Configuration writes are taken during the clear.
module scan_packet_line_assembler_core import spla_pkg::*; #(
  parameter int PACKET_BYTES      = PACKET_BYTES_DEF,
  parameter int PIXEL_OFFSET      = PIXEL_OFFSET_DEF,
  parameter int PIXELS_PER_PACKET = PIXELS_PER_PACKET_DEF,
  parameter int BLOCKS_PER_LINE   = BLOCKS_PER_LINE_DEF,
  parameter int MAX_SLOTS         = MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,   // command
  input  logic [23:0] s_axis_tdata,   // data_byte, capture_enable, read_address, pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // line_committed, scan_line, slot_index, frame_full, read_data, pad
  output logic [47:0] m_axis_tdata
);

  localparam int STORE_BYTES = PIXELS_PER_PACKET * BLOCKS_PER_LINE;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  logic              space;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              meta_valid;
  meta_t             meta;
  result_t           out_result;

  spla_front #(
    .PACKET_BYTES      (PACKET_BYTES),
    .PIXEL_OFFSET      (PIXEL_OFFSET),
    .PIXELS_PER_PACKET (PIXELS_PER_PACKET),
    .BLOCKS_PER_LINE   (BLOCKS_PER_LINE),
    .MAX_SLOTS         (MAX_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser),
    .in_data    (s_axis_tdata[7:0]),
    .in_capture (s_axis_tdata[8]),
    .in_raddr   (s_axis_tdata[19:9]),
    .space      (space),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .meta_valid (meta_valid),
    .meta       (meta)
  );

  spla_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spla_back u_back (
    .clk        (clk),
    .rst        (rst),
    .meta_valid (meta_valid),
    .meta       (meta),
    .ram_rdata  (ram_rdata),
    .space      (space),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (out_result)
  );

  assign m_axis_tdata = {5'd0, out_result};

endmodule

[hdl/spla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module spla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1728
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/spla_front.sv]
// Front end: accepts items, tracks packet position and header, drives line store.
module spla_front import spla_pkg::*; #(
  parameter int PACKET_BYTES      = PACKET_BYTES_DEF,
  parameter int PIXEL_OFFSET      = PIXEL_OFFSET_DEF,
  parameter int PIXELS_PER_PACKET = PIXELS_PER_PACKET_DEF,
  parameter int BLOCKS_PER_LINE   = BLOCKS_PER_LINE_DEF,
  parameter int MAX_SLOTS         = MAX_SLOTS_DEF,
  localparam int STORE_BYTES      = PIXELS_PER_PACKET * BLOCKS_PER_LINE,
  localparam int ADDR_W           = $clog2(STORE_BYTES),
  localparam int POS_W            = $clog2(PACKET_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [12:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_data,
  input  logic              in_capture,
  input  logic [10:0]       in_raddr,
  input  logic              space,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  output logic              meta_valid,
  output meta_t             meta
);

  logic [12:0]       line_limit;
  logic [POS_W-1:0]  byte_position;
  logic              header_good;
  logic [19:0]       packet_line;
  logic [3:0]        packet_block;
  logic [ADDR_W-1:0] block_base;
  logic              first_block_seen;
  logic [12:0]       slot_count;
  logic              full_flag;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  cmd_t        cmd;
  logic        accept;
  logic        block_valid;
  logic        last_byte;
  logic        pix_write;
  logic        commit;
  logic [12:0] slot_inc;
  logic        full_after;
  logic        read_ok;
  logic [31:0] wr_calc;
  logic [31:0] base_calc;

  assign cmd      = cmd_t'(in_command);
  assign in_ready = !clearing && space;
  assign accept   = in_valid && in_ready;

  assign block_valid = header_good && (packet_block >= 4'd1) &&
                       (32'(packet_block) <= 32'(BLOCKS_PER_LINE));
  assign last_byte   = (32'(byte_position) == 32'(PACKET_BYTES - 1));
  assign slot_inc    = slot_count + 13'd1;
  assign wr_calc     = 32'(block_base) + 32'(byte_position) - 32'(PIXEL_OFFSET);
  assign base_calc   = (32'(in_data[3:0]) - 32'd1) * 32'(PIXELS_PER_PACKET);

  always_comb begin
    pix_write  = 1'b0;
    commit     = 1'b0;
    full_after = full_flag;
    read_ok    = 1'b0;
    case (cmd)
      CMD_PACKET: begin
        pix_write = block_valid &&
                    (32'(byte_position) >= 32'(PIXEL_OFFSET)) &&
                    (32'(byte_position) < 32'(PIXEL_OFFSET + PIXELS_PER_PACKET));
        commit = last_byte && block_valid &&
                 (32'(packet_block) == 32'(BLOCKS_PER_LINE)) &&
                 first_block_seen && in_capture && !full_flag;
        if (commit) begin
          full_after = (slot_inc >= line_limit) || (32'(slot_inc) >= 32'(MAX_SLOTS));
        end
      end
      CMD_READ: begin
        read_ok = (32'(in_raddr) < 32'(STORE_BYTES));
      end
      CMD_NEW_FRAME: begin
        full_after = 1'b0;
      end
      default: begin
        full_after = full_flag;
      end
    endcase
  end

  // Clearing pass owns the write port after reset
  assign ram_we    = clearing || (accept && pix_write);
  assign ram_waddr = clearing ? clr_addr : wr_calc[ADDR_W-1:0];
  assign ram_wdata = clearing ? 8'd0 : in_data;
  assign ram_raddr = ADDR_W'(in_raddr);

  assign meta_valid       = accept;
  assign meta.is_read     = read_ok;
  assign meta.committed   = commit;
  assign meta.scan_line   = commit ? packet_line : 20'd0;
  assign meta.slot_index  = commit ? slot_count : 13'd0;
  assign meta.frame_full  = full_after;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (32'(clr_addr) == 32'(STORE_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      line_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      header_good      <= 1'b0;
      packet_line      <= '0;
      packet_block     <= '0;
      block_base       <= '0;
      first_block_seen <= 1'b0;
      slot_count       <= '0;
      full_flag        <= 1'b0;
    end else if (accept) begin
      full_flag <= full_after;
      if (cmd == CMD_NEW_FRAME) begin
        slot_count <= '0;
      end
      if (cmd == CMD_PACKET) begin
        if (32'(byte_position) == POS_HEADER) begin
          header_good <= (in_data == HEADER_MARK);
        end
        if (32'(byte_position) == POS_LINE_LO) begin
          packet_line[7:0] <= in_data;
        end
        if (32'(byte_position) == POS_LINE_MID) begin
          packet_line[15:8] <= in_data;
        end
        if (32'(byte_position) == POS_LINE_HI) begin
          packet_line[19:16] <= in_data[7:4];
          packet_block       <= in_data[3:0];
          block_base         <= base_calc[ADDR_W-1:0];
          if (header_good && in_data[3:0] == 4'd1) begin
            first_block_seen <= 1'b1;
          end
        end
        if (commit) begin
          slot_count <= slot_inc;
        end
        // Wrap at the packet end
        byte_position <= last_byte ? '0 : byte_position + POS_W'(1);
      end
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("item accepted during line store clear");

  a_commit_advances_slot: assert property (@(posedge clk) disable iff (rst)
    accept && commit |=> slot_count == $past(slot_inc))
    else $error("commit did not advance slot count");

  a_full_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(full_flag) |-> $past(accept && commit))
    else $error("frame full set without a commit");

endmodule

[hdl/spla_back.sv]
// Back end: merges read data into result items and queues them for output.
module spla_back import spla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        meta_valid,
  input  meta_t       meta,
  input  logic [7:0]  ram_rdata,
  output logic        space,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_result
);

  logic             stage_valid;
  meta_t            stage_meta;
  result_t          stage_result;
  result_t          queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic             pop;

  // Room for every item already accepted upstream
  assign space = (32'(count) + 32'(stage_valid)) < QUEUE_DEPTH;

  assign stage_result.read_data      = stage_meta.is_read ? ram_rdata : 8'd0;
  assign stage_result.frame_full     = stage_meta.frame_full;
  assign stage_result.slot_index     = stage_meta.slot_index;
  assign stage_result.scan_line      = stage_meta.scan_line;
  assign stage_result.line_committed = stage_meta.committed;

  assign out_valid  = (count != '0);
  assign out_result = queue[rd_ptr];
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= meta_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meta_valid) begin
      stage_meta <= meta;
    end
    if (stage_valid) begin
      queue[wr_ptr] <= stage_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (stage_valid) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({stage_valid, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    stage_valid |-> (32'(count) < QUEUE_DEPTH) || pop)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("result queue count out of range");

endmodule

[tb/tb.sv]
// Testbench for the scan packet line assembler: directed and random packet traffic.
`timescale 1ns / 1ps

module tb;
  import spla_pkg::*;

  localparam int STORE_BYTES = PIXELS_PER_PACKET_DEF * BLOCKS_PER_LINE_DEF;
  localparam int LAST_POS = PACKET_BYTES_DEF - 1;
  localparam int PIXEL_END = PIXEL_OFFSET_DEF + PIXELS_PER_PACKET_DEF;
  localparam int STALL_LIMIT = 8000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [12:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = CMD_NOP;  // command
  logic [23:0] s_axis_tdata = '0;       // data_byte, capture_enable, read_address, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // line_committed, scan_line, slot_index, frame_full, read_data, pad
  logic [47:0] m_axis_tdata;

  scan_packet_line_assembler_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Assembler state as the testbench expects it
  logic [7:0]  byte_pos;
  logic        header_ok;
  logic [19:0] hdr_line;
  logic [3:0]  hdr_block;
  logic        block1_seen;
  logic [7:0]  line_mem [0:STORE_BYTES-1];
  logic [12:0] slots_used;
  logic        frame_is_full;
  logic [12:0] line_limit;

  result_t expected_results[$];
  int      errors = 0;
  int      src_idle_pct = 0;
  int      sink_idle_pct = 0;
  int      quiet_cycles = 0;

  function automatic result_t assemble_line_step(cmd_t cmd, logic [7:0] data, logic cap,
                                                 logic [10:0] addr);
    result_t res;
    logic    block_ok;
    res = '0;
    case (cmd)
      CMD_PACKET: begin
        case (int'(byte_pos))
          POS_HEADER:   header_ok = (data == HEADER_MARK);
          POS_LINE_LO:  hdr_line[7:0] = data;
          POS_LINE_MID: hdr_line[15:8] = data;
          POS_LINE_HI: begin
            hdr_line[19:16] = data[7:4];
            hdr_block = data[3:0];
            if (header_ok && hdr_block == 4'd1) block1_seen = 1'b1;
          end
          default: ;
        endcase
        block_ok = header_ok && hdr_block >= 4'd1 && hdr_block <= 4'(BLOCKS_PER_LINE_DEF);
        if (block_ok && byte_pos >= PIXEL_OFFSET_DEF && byte_pos < PIXEL_END)
          line_mem[(hdr_block - 1) * PIXELS_PER_PACKET_DEF + (byte_pos - PIXEL_OFFSET_DEF)] = data;
        if (byte_pos == LAST_POS) begin
          if (block_ok && hdr_block == 4'(BLOCKS_PER_LINE_DEF) && block1_seen && cap &&
              !frame_is_full) begin
            res.line_committed = 1'b1;
            res.scan_line = hdr_line;
            res.slot_index = slots_used;
            slots_used = slots_used + 13'd1;
            if (slots_used >= line_limit || slots_used >= MAX_SLOTS_DEF) frame_is_full = 1'b1;
          end
          byte_pos = '0;
        end else begin
          byte_pos = byte_pos + 8'd1;
        end
      end
      CMD_READ: begin
        if (addr < STORE_BYTES) res.read_data = line_mem[addr];
      end
      CMD_NEW_FRAME: begin
        slots_used = '0;
        frame_is_full = 1'b0;
      end
      default: ;
    endcase
    res.frame_full = frame_is_full;
    return res;
  endfunction

  task automatic send_item(cmd_t cmd, logic [7:0] data, logic cap, logic [10:0] addr);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, addr, cap, data};
    do @(posedge clk); while (!s_axis_tready);
    expected_results.push_back(assemble_line_step(cmd, data, cap, addr));
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_line_limit(logic [12:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_limit = value;
  endtask

  // One packet from the current byte position to its last byte, with
  // occasional read, new-frame and no-op items mixed in.
  task automatic send_scan_packet();
    logic        hdr_good;
    logic [3:0]  blk;
    logic [19:0] line_no;
    logic [7:0]  b;
    logic        cap;
    logic        done;
    int          p;
    int          r;
    hdr_good = $urandom_range(99) < 88;
    line_no = 20'($urandom);
    r = $urandom_range(99);
    if (!block1_seen && r < 70) blk = 4'd1;
    else if (r < 55) blk = 4'(BLOCKS_PER_LINE_DEF);
    else if (r < 65) blk = 4'd1;
    else if (r < 85) blk = 4'($urandom_range(2, BLOCKS_PER_LINE_DEF - 1));
    else begin
      r = $urandom_range(0, 7);
      blk = (r == 0) ? 4'd0 : 4'(BLOCKS_PER_LINE_DEF + r);
    end
    done = 1'b0;
    while (!done) begin
      if ($urandom_range(99) < 3) begin
        r = $urandom_range(0, 9);
        if (r < 6)
          send_item(CMD_READ, 8'($urandom), 1'($urandom),
                    ($urandom_range(99) < 85) ? 11'($urandom_range(0, STORE_BYTES - 1))
                                              : 11'($urandom_range(STORE_BYTES, 2047)));
        else if (r < 8)
          send_item(CMD_NEW_FRAME, 8'($urandom), 1'($urandom), 11'($urandom));
        else
          send_item(CMD_NOP, 8'($urandom), 1'($urandom), 11'($urandom));
      end
      p = int'(byte_pos);
      case (p)
        POS_HEADER:   b = hdr_good ? HEADER_MARK : 8'($urandom);
        POS_LINE_LO:  b = line_no[7:0];
        POS_LINE_MID: b = line_no[15:8];
        POS_LINE_HI:  b = {line_no[19:16], blk};
        default:      b = 8'($urandom);
      endcase
      cap = (p == LAST_POS) ? ($urandom_range(99) < 85) : 1'($urandom);
      send_item(CMD_PACKET, b, cap, 11'($urandom));
      done = (p == LAST_POS);
    end
  endtask

  task automatic run_capture_phase(int src_pct, int sink_pct, logic [12:0] limit);
    wait_results_done();
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    write_line_limit(limit);
    send_scan_packet();
  endtask

  // Store reads at its edges, a no-op, a new frame and a well-formed block 1 header
  task automatic test_directed_edges();
    logic [7:0] hdr_bytes [0:7];
    hdr_bytes = '{8'h00, 8'hFF, 8'h5A, 8'hA5, HEADER_MARK, 8'hFF, 8'hFF, 8'hF1};
    write_line_limit(13'h1FFF);
    send_item(CMD_READ, 8'h00, 1'b0, 11'd0);
    send_item(CMD_READ, 8'hFF, 1'b1, 11'(STORE_BYTES - 1));
    send_item(CMD_READ, 8'h00, 1'b0, 11'(STORE_BYTES));
    send_item(CMD_READ, 8'h00, 1'b1, 11'h7FF);
    send_item(CMD_NOP, 8'hFF, 1'b1, 11'h7FF);
    send_item(CMD_NEW_FRAME, 8'hFF, 1'b1, 11'h7FF);
    for (int i = 0; i < 8; i++) send_item(CMD_PACKET, hdr_bytes[i], 1'(i), 11'h7FF);
    send_item(CMD_NOP, 8'h00, 1'b0, 11'd0);
    send_item(CMD_READ, 8'h00, 1'b0, 11'd0);
  endtask

  task automatic test_single_line_frame();
    run_capture_phase(35, 65, 13'd1);
  endtask

  task automatic test_full_size_frame();
    run_capture_phase(65, 35, 13'(MAX_SLOTS_DEF));
  endtask

  task automatic test_zero_limit();
    run_capture_phase(0, 0, 13'd0);
  endtask

  function automatic void check_field(string what, logic [19:0] want, logic [19:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("line_committed", 20'(want.line_committed), 20'(got.line_committed));
        check_field("scan_line", want.scan_line, got.scan_line);
        check_field("slot_index", 20'(want.slot_index), 20'(got.slot_index));
        check_field("frame_full", 20'(want.frame_full), 20'(got.frame_full));
        check_field("read_data", 20'(want.read_data), 20'(got.read_data));
      end
    end
  end

  // Abort when the block stops moving items
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    byte_pos = '0;
    header_ok = 1'b0;
    hdr_line = '0;
    hdr_block = '0;
    block1_seen = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) line_mem[i] = '0;
    slots_used = '0;
    frame_is_full = 1'b0;
    line_limit = LIMIT_RESET;
    src_idle_pct = 35;
    sink_idle_pct = 65;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_single_line_frame();
    test_full_size_frame();
    test_zero_limit();
    wait_results_done();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
